@@ rtl/core/mbpl_pkg.sv @@
// ----------------------------------------------------------------------------
// mbpl_pkg
// shared types and constants of the mix bus peak limiter
// ----------------------------------------------------------------------------
package mbpl_pkg;

  localparam int NUM_SOURCES_DEF = 4;
  localparam int MAX_SOURCES     = 4;
  localparam int SMP_W           = 24;
  localparam int GAIN_W          = 17;
  localparam int CEIL_W          = 25;
  localparam int BUS_W           = 30;
  localparam int LGAIN_W         = 25;
  localparam int PROD_W          = SMP_W + GAIN_W + 1;
  localparam int ACC_W           = PROD_W + 2;
  localparam int NUM_W           = CEIL_W + 23;
  localparam int IDX_W           = 3;

  localparam logic [GAIN_W-1:0]  MASTER_RST = 17'd16384;
  localparam logic [CEIL_W-1:0]  CEIL_RST   = 25'd14953435;
  localparam logic [LGAIN_W-1:0] UNITY_Q24  = 25'd16777216;
  localparam logic [BUS_W-1:0]   BUS_MAX    = 30'h3FFFFFFF;
  localparam logic [15:0]        RECOVER_Q24 = 16'd33554;

  localparam logic [IDX_W-1:0] REG_SRC0    = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC1    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SRC2    = 3'd2;
  localparam logic [IDX_W-1:0] REG_SRC3    = 3'd3;
  localparam logic [IDX_W-1:0] REG_MASTER  = 3'd4;
  localparam logic [IDX_W-1:0] REG_CEILING = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_MST, S_MAG, S_DIV, S_DIVEND, S_REC, S_RADD, S_APP, S_OUT
  } state_e;

endpackage

@@ rtl/core/mix_bus_peak_limiter_top.sv @@
// ----------------------------------------------------------------------------
// mix_bus_peak_limiter_top
// four-source stereo mix bus with master gain and brickwall peak limiter
// ----------------------------------------------------------------------------
// One frame is processed at a time. The source lanes weight their samples in
// parallel, a merge stage sums them and applies the master gain, and the
// limiter then updates its gain and scales both channels. A new frame is
// taken only once the last one has reached the output register, and a frame
// on which the limiter engages takes longer than one on which it recovers,
// the extra time being the 48-step serial divider that forms ceiling / peak.
// A finished frame waits in the output register, so the next frame is taken
// meanwhile. Block peak and minimum gain appear on the frame marked with
// s_tlast_i.
module mix_bus_peak_limiter_top
  import mbpl_pkg::*;
#(
  parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_index_i,
  input  logic [CEIL_W-1:0]   cfg_wdata_i,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  // src0_left, src0_right, src1_left, src1_right, src2_left, src2_right,
  // src3_left, src3_right
  input  logic [191:0]        s_tdata_i,
  input  logic                s_tlast_i,   // block_last
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  // out_left, out_right, block_peak, block_min_gain, zero pad
  output logic [103:0]        m_tdata_o,
  output logic                m_tuser_o    // meter_valid
);

  state_e state_q, state_d;

  logic [GAIN_W-1:0]  route_q [MAX_SOURCES];
  logic [GAIN_W-1:0]  master_q;
  logic [CEIL_W-1:0]  ceil_q;
  logic [LGAIN_W-1:0] lgain_q, mingain_q;
  logic [BUS_W-1:0]   peak_acc_q;
  logic               last_q;

  logic signed [PROD_W-1:0] lane_l [NUM_SOURCES];
  logic signed [PROD_W-1:0] lane_r [NUM_SOURCES];
  logic signed [ACC_W-1:0]  acc_l_d, acc_r_d, acc_l_q, acc_r_q;
  logic signed [ACC_W+GAIN_W:0] p_l_q, p_r_q;
  logic [ACC_W+GAIN_W:0]    abs_l, abs_r;
  logic [ACC_W+GAIN_W+1:0]  rnd_l, rnd_r;
  logic [BUS_W-1:0]         ml_d, mr_d, ml_q, mr_q, peak_d;
  logic                     nl_q, nr_q;
  logic                     engage;
  logic                     s_acc;

  logic                     div_start, div_busy;
  logic [NUM_W-1:0]         div_quot;

  logic [40:0]              rec_prod_q;
  logic [LGAIN_W-1:0]       rec_gap;
  logic [41:0]              rec_sum;
  logic [LGAIN_W:0]         gain_sum;

  logic [BUS_W+LGAIN_W-1:0] app_l_q, app_r_q;
  logic [BUS_W+LGAIN_W:0]   ar_l, ar_r;
  logic [SMP_W-1:0]         out_l, out_r;
  logic                     out_free;

  logic [103:0]             m_tdata_q;
  logic                     m_tvalid_q, m_tuser_q;

  assign s_acc = s_tvalid_i && s_tready_o;

  // lanes
  for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_lane
    mbpl_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (s_acc),
      .left_i   ($signed(s_tdata_i[2*i*SMP_W +: SMP_W])),
      .right_i  ($signed(s_tdata_i[(2*i+1)*SMP_W +: SMP_W])),
      .gain_i   (route_q[i]),
      .prod_l_o (lane_l[i]),
      .prod_r_o (lane_r[i])
    );
  end

  // merge
  always_comb begin
    acc_l_d = '0;
    acc_r_d = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      acc_l_d = acc_l_d + ACC_W'(lane_l[i]);
      acc_r_d = acc_r_d + ACC_W'(lane_r[i]);
    end
  end

  always_comb begin
    abs_l = p_l_q[ACC_W+GAIN_W] ? $unsigned(-p_l_q) : $unsigned(p_l_q);
    abs_r = p_r_q[ACC_W+GAIN_W] ? $unsigned(-p_r_q) : $unsigned(p_r_q);
    rnd_l = {1'b0, abs_l} + (ACC_W+GAIN_W+2)'(28'h8000000);
    rnd_r = {1'b0, abs_r} + (ACC_W+GAIN_W+2)'(28'h8000000);
    ml_d  = (rnd_l[ACC_W+GAIN_W+1:28] > (ACC_W+GAIN_W-26)'(BUS_MAX)) ? BUS_MAX
                                                        : rnd_l[BUS_W+27:28];
    mr_d  = (rnd_r[ACC_W+GAIN_W+1:28] > (ACC_W+GAIN_W-26)'(BUS_MAX)) ? BUS_MAX
                                                        : rnd_r[BUS_W+27:28];
    peak_d = (ml_d > mr_d) ? ml_d : mr_d;
    engage = (peak_d != '0) && ({peak_d, 1'b0} > (BUS_W+1)'(ceil_q));
  end

  assign div_start = (state_q == S_MAG) && engage;

  mbpl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({ceil_q, 23'd0}),
    .den_i   (peak_d),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  assign rec_gap  = UNITY_Q24 - lgain_q;
  assign rec_sum  = {1'b0, rec_prod_q} + 42'(24'hFFFFFF);
  assign gain_sum = {1'b0, lgain_q} + (LGAIN_W+1)'(rec_sum[41:24]);

  always_comb begin
    ar_l = {1'b0, app_l_q} + (BUS_W+LGAIN_W+1)'(24'h800000);
    ar_r = {1'b0, app_r_q} + (BUS_W+LGAIN_W+1)'(24'h800000);
    if (nl_q) begin
      out_l = (ar_l[BUS_W+LGAIN_W:24] > 32'd8388608) ? 24'h800000
                                                      : SMP_W'(-ar_l[47:24]);
    end else begin
      out_l = (ar_l[BUS_W+LGAIN_W:24] > 32'd8388607) ? 24'h7FFFFF : ar_l[47:24];
    end
    if (nr_q) begin
      out_r = (ar_r[BUS_W+LGAIN_W:24] > 32'd8388608) ? 24'h800000
                                                      : SMP_W'(-ar_r[47:24]);
    end else begin
      out_r = (ar_r[BUS_W+LGAIN_W:24] > 32'd8388607) ? 24'h7FFFFF : ar_r[47:24];
    end
  end

  assign out_free = !m_tvalid_q || m_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (s_tvalid_i) state_d = S_SUM;
      S_SUM:    state_d = S_MST;
      S_MST:    state_d = S_MAG;
      S_MAG:    state_d = engage ? S_DIV : S_REC;
      S_DIV:    if (!div_busy) state_d = S_DIVEND;
      S_DIVEND: state_d = S_APP;
      S_REC:    state_d = S_RADD;
      S_RADD:   state_d = S_APP;
      S_APP:    state_d = S_OUT;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready_o = 1'b0;
    case (state_q)
      S_IDLE:  s_tready_o = 1'b1;
      default: s_tready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      for (int i = 0; i < MAX_SOURCES; i++) route_q[i] <= '0;
      master_q   <= MASTER_RST;
      ceil_q     <= CEIL_RST;
      lgain_q    <= UNITY_Q24;
      mingain_q  <= UNITY_Q24;
      peak_acc_q <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i < IDX_W'(MAX_SOURCES)) begin
          route_q[cfg_index_i[1:0]] <= cfg_wdata_i[GAIN_W-1:0];
        end else if (cfg_index_i == REG_MASTER) begin
          master_q <= cfg_wdata_i[GAIN_W-1:0];
        end else if (cfg_index_i == REG_CEILING) begin
          ceil_q <= cfg_wdata_i;
        end
      end
      if (state_q == S_MAG && peak_d > peak_acc_q) peak_acc_q <= peak_d;
      if (state_q == S_DIVEND && div_quot < NUM_W'(lgain_q)) begin
        lgain_q <= div_quot[LGAIN_W-1:0];
      end
      if (state_q == S_RADD) begin
        lgain_q <= (gain_sum > {1'b0, UNITY_Q24}) ? UNITY_Q24 : gain_sum[LGAIN_W-1:0];
      end
      if (state_q == S_APP && lgain_q < mingain_q) mingain_q <= lgain_q;
      if (state_q == S_OUT && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      if (state_q == S_OUT && out_free && last_q) begin
        peak_acc_q <= '0;
        mingain_q  <= UNITY_Q24;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) last_q <= s_tlast_i;
    if (state_q == S_SUM) begin
      acc_l_q <= acc_l_d;
      acc_r_q <= acc_r_d;
    end
    if (state_q == S_MST) begin
      p_l_q <= acc_l_q * $signed({1'b0, master_q});
      p_r_q <= acc_r_q * $signed({1'b0, master_q});
    end
    if (state_q == S_MAG) begin
      ml_q <= ml_d;
      mr_q <= mr_d;
      nl_q <= p_l_q[ACC_W+GAIN_W];
      nr_q <= p_r_q[ACC_W+GAIN_W];
    end
    if (state_q == S_REC) rec_prod_q <= rec_gap * RECOVER_Q24;
    if (state_q == S_APP) begin
      app_l_q <= ml_q * lgain_q;
      app_r_q <= mr_q * lgain_q;
    end
    if (state_q == S_OUT && out_free) begin
      m_tuser_q <= last_q;
      m_tdata_q <= {1'b0,
                    last_q ? mingain_q : {LGAIN_W{1'b0}},
                    last_q ? peak_acc_q : {BUS_W{1'b0}},
                    out_r, out_l};
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

  a_gain_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lgain_q <= UNITY_Q24) else $error("limiter gain above unity");

  a_min_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mingain_q <= UNITY_Q24) else $error("minimum gain above unity");

  a_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == S_DIV) else $error("divider busy outside divide");

  a_meter_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tuser_o) |-> m_tdata_o[102:48] == '0)
    else $error("meter fields set on a beat not marked last");

endmodule

@@ rtl/core/mbpl_lane.sv @@
// ----------------------------------------------------------------------------
// mbpl_lane
// one source lane: weights the stereo pair by its route gain
// ----------------------------------------------------------------------------
module mbpl_lane
  import mbpl_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [SMP_W-1:0]  left_i,
  input  logic signed [SMP_W-1:0]  right_i,
  input  logic [GAIN_W-1:0]        gain_i,
  output logic signed [PROD_W-1:0] prod_l_o,
  output logic signed [PROD_W-1:0] prod_r_o
);

  logic signed [PROD_W-1:0] prod_l_d, prod_r_d, prod_l_q, prod_r_q;
  logic signed [GAIN_W:0]   g;

  assign g        = $signed({1'b0, gain_i});
  assign prod_l_d = left_i * g;
  assign prod_r_d = right_i * g;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
    end
  end

  assign prod_l_o = prod_l_q;
  assign prod_r_o = prod_r_q;

endmodule

@@ rtl/core/mbpl_div.sv @@
// ----------------------------------------------------------------------------
// mbpl_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mbpl_div
  import mbpl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [BUS_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BUS_W-1:0] rem_q, rem_d, den_q;
  logic [NUM_W-1:0] shf_q, shf_d;
  logic [BUS_W:0]   trial;

  always_comb begin
    trial = {rem_q, shf_q[NUM_W-1]};
    cnt_d = cnt_q;
    rem_d = rem_q;
    shf_d = shf_q;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
      rem_d = '0;
      shf_d = num_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = BUS_W'(trial - {1'b0, den_q});
        shf_d = {shf_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[BUS_W-1:0];
        shf_d = {shf_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    shf_q <= shf_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = shf_q;

endmodule
